### rtl/core/mmr_pkg.sv
// Shared types and constants for the coprocessor host register window.
package mmr_pkg;

	// Request commands
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_HALT  = 2'd2;

	// Address blocks within the 10-bit window
	localparam logic [4:0] CTL_BLOCK = 5'b11010; // 0x340-0x35F
	localparam logic [4:0] VEC_BLOCK = 5'b11011; // 0x360-0x37F
	localparam logic [2:0] GPR_BLOCK = 3'b111;   // 0x380-0x3FF, both mirrors
	localparam logic [5:0] GPR_LIMIT = 6'd48;    // 16 regs x 3 byte lanes

	// Status byte values
	localparam logic [7:0] STATUS_RUN  = 8'h40;
	localparam logic [7:0] STATUS_HALT = 8'h02;

	// Write masks
	localparam logic [7:0] CTL_C_MASK = 8'h77;

	// Decoded register selection
	typedef enum logic [3:0] {
		SEL_NONE,
		SEL_DMA_SRC,
		SEL_DMA_LEN,
		SEL_DMA_DST,
		SEL_CTL_A,
		SEL_PROG,
		SEL_CTL_B,
		SEL_PAGE,
		SEL_PC,
		SEL_CTL_C,
		SEL_CTL_D,
		SEL_CTL_E,
		SEL_STATUS,
		SEL_VEC,
		SEL_GPR
	} sel_t;

	typedef struct packed {
		sel_t       sel;
		logic [1:0] lane;
		logic [3:0] gpr_idx;
		logic [4:0] vec_idx;
	} dec_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [9:0] offset;
		logic [7:0] wdata;
	} req_t;

	typedef struct packed {
		logic [7:0]  rdata;
		logic        dma_request;
		logic        run_start;
		logic [22:0] start_pc;
		logic        running;
	} rsp_t;

endpackage

### rtl/core/coprocessor_mmio_register_file.sv
// Top level of the coprocessor host register window.
// A request is held in the input register, decoded, and its result is held in the result register.
// Throughput: one request every cycle; busy stays low, as each request is a single decode.
// The result is shown for one cycle with done and cannot be held off.
// Reset (arst_n low): all window registers, vector table and general registers clear,
// the core reads as halted.
module coprocessor_mmio_register_file (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mmr_pkg::req_t req,
	output logic          done,
	output mmr_pkg::rsp_t rsp
);

	logic          valid_s1;
	mmr_pkg::req_t req_s1;
	mmr_pkg::dec_t dec;

	assign busy = 1'b0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// Offset decode
	mmr_decode u_decode (
		.offset (req_s1.offset),
		.dec    (dec)
	);

	// State, read mux and result register
	mmr_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1),
		.dec      (dec),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

### rtl/core/mmr_decode.sv
// Offset decoder: maps a window offset to a register, byte lane and index.
module mmr_decode (
	input  logic [9:0]    offset,
	output mmr_pkg::dec_t dec
);

	logic [5:0]  lo;
	logic [11:0] prod;
	logic [3:0]  idx;
	logic [5:0]  lane_full;

	// General register index is lo/3 via reciprocal 43/128, exact for lo < 48
	assign lo        = offset[5:0];
	assign prod      = 12'(lo) * 12'd43;
	assign idx       = prod[10:7];
	assign lane_full = lo - 6'({2'b00, idx} * 6'd3);

	// Region and lane decode
	always_comb begin
		dec.sel     = mmr_pkg::SEL_NONE;
		dec.lane    = 2'd0;
		dec.gpr_idx = idx;
		dec.vec_idx = offset[4:0];
		if (offset[9:5] == mmr_pkg::CTL_BLOCK) begin
			unique case (offset[4:0])
				5'h00, 5'h01, 5'h02: begin
					dec.sel  = mmr_pkg::SEL_DMA_SRC;
					dec.lane = offset[1:0];
				end
				5'h03, 5'h04: begin
					dec.sel  = mmr_pkg::SEL_DMA_LEN;
					dec.lane = 2'(offset[4:0] - 5'h03);
				end
				5'h05, 5'h06, 5'h07: begin
					dec.sel  = mmr_pkg::SEL_DMA_DST;
					dec.lane = 2'(offset[4:0] - 5'h05);
				end
				5'h08: dec.sel = mmr_pkg::SEL_CTL_A;
				5'h09, 5'h0A, 5'h0B: begin
					dec.sel  = mmr_pkg::SEL_PROG;
					dec.lane = 2'(offset[4:0] - 5'h09);
				end
				5'h0C: dec.sel = mmr_pkg::SEL_CTL_B;
				5'h0D, 5'h0E: begin
					dec.sel  = mmr_pkg::SEL_PAGE;
					dec.lane = 2'(offset[4:0] - 5'h0D);
				end
				5'h0F: dec.sel = mmr_pkg::SEL_PC;
				5'h10: dec.sel = mmr_pkg::SEL_CTL_C;
				5'h11: dec.sel = mmr_pkg::SEL_CTL_D;
				5'h12: dec.sel = mmr_pkg::SEL_CTL_E;
				default: dec.sel = mmr_pkg::SEL_STATUS;
			endcase
		end else if (offset[9:5] == mmr_pkg::VEC_BLOCK) begin
			dec.sel = mmr_pkg::SEL_VEC;
		end else if (offset[9:7] == mmr_pkg::GPR_BLOCK && lo < mmr_pkg::GPR_LIMIT) begin
			dec.sel  = mmr_pkg::SEL_GPR;
			dec.lane = lane_full[1:0];
		end
	end

endmodule

### rtl/core/mmr_regs.sv
// Register state, read mux and result register of the host window.
module mmr_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  mmr_pkg::req_t req_s1,
	input  mmr_pkg::dec_t dec,
	output logic          done,
	output mmr_pkg::rsp_t rsp
);

	logic [23:0] dma_src_q;
	logic [15:0] dma_len_q;
	logic [23:0] dma_dst_q;
	logic [23:0] prog_base_q;
	logic [14:0] page_reg_q;
	logic [7:0]  pc_byte_q;
	logic        ctl_a_q;
	logic [1:0]  ctl_b_q;
	logic [7:0]  ctl_c_q;
	logic        ctl_d_q;
	logic        ctl_e_q;
	logic [7:0]  vec_q [32];
	logic [23:0] gpr_q [16];
	logic        halted_q;

	logic          is_rd;
	logic          is_wr;
	logic          is_halt;
	logic [7:0]    d;
	logic [23:0]   gpr_word;
	logic [7:0]    rd_byte;
	logic          halted_next;
	logic          pc_release;
	mmr_pkg::rsp_t rsp_c;
	mmr_pkg::rsp_t rsp_q;
	logic          done_q;

	assign is_rd   = valid_s1 && req_s1.cmd == mmr_pkg::CMD_READ;
	assign is_wr   = valid_s1 && req_s1.cmd == mmr_pkg::CMD_WRITE;
	assign is_halt = valid_s1 && req_s1.cmd == mmr_pkg::CMD_HALT;
	assign d       = req_s1.wdata;

	// Replace one byte lane of a 24-bit word
	function automatic logic [23:0] put_lane(logic [23:0] w, logic [1:0] lane,
		logic [7:0] b);
		logic [23:0] r;
		r = w;
		case (lane)
			2'd0:    r[7:0]   = b;
			2'd1:    r[15:8]  = b;
			default: r[23:16] = b;
		endcase
		return r;
	endfunction

	// Pick one byte lane of a 24-bit word
	function automatic logic [7:0] get_lane(logic [23:0] w, logic [1:0] lane);
		logic [7:0] r;
		case (lane)
			2'd0:    r = w[7:0];
			2'd1:    r = w[15:8];
			default: r = w[23:16];
		endcase
		return r;
	endfunction

	assign gpr_word = gpr_q[dec.gpr_idx];

	// Read mux
	always_comb begin
		unique case (dec.sel)
			mmr_pkg::SEL_DMA_SRC: rd_byte = get_lane(dma_src_q, dec.lane);
			mmr_pkg::SEL_DMA_LEN: rd_byte = dec.lane[0] ? dma_len_q[15:8] : dma_len_q[7:0];
			mmr_pkg::SEL_DMA_DST: rd_byte = get_lane(dma_dst_q, dec.lane);
			mmr_pkg::SEL_CTL_A:   rd_byte = {7'd0, ctl_a_q};
			mmr_pkg::SEL_PROG:    rd_byte = get_lane(prog_base_q, dec.lane);
			mmr_pkg::SEL_CTL_B:   rd_byte = {6'd0, ctl_b_q};
			mmr_pkg::SEL_PAGE:
				rd_byte = dec.lane[0] ? {1'b0, page_reg_q[14:8]} : page_reg_q[7:0];
			mmr_pkg::SEL_PC:      rd_byte = pc_byte_q;
			mmr_pkg::SEL_CTL_C:   rd_byte = ctl_c_q;
			mmr_pkg::SEL_CTL_D:   rd_byte = {7'd0, ctl_d_q};
			mmr_pkg::SEL_CTL_E:   rd_byte = {7'd0, ctl_e_q};
			mmr_pkg::SEL_STATUS:
				rd_byte = halted_q ? mmr_pkg::STATUS_HALT : mmr_pkg::STATUS_RUN;
			mmr_pkg::SEL_VEC:     rd_byte = vec_q[dec.vec_idx];
			mmr_pkg::SEL_GPR:     rd_byte = get_lane(gpr_word, dec.lane);
			default:              rd_byte = 8'd0;
		endcase
	end

	// Run control and result
	always_comb begin
		pc_release  = is_wr && dec.sel == mmr_pkg::SEL_PC && halted_q;
		halted_next = halted_q;
		if (is_halt) begin
			halted_next = 1'b1;
		end else if (pc_release) begin
			halted_next = 1'b0;
		end
		rsp_c.rdata       = is_rd ? rd_byte : 8'd0;
		rsp_c.dma_request = is_wr && dec.sel == mmr_pkg::SEL_DMA_DST && dec.lane == 2'd2
			&& halted_q;
		rsp_c.run_start   = pc_release;
		rsp_c.start_pc    = pc_release ? {page_reg_q, d} : 23'd0;
		rsp_c.running     = !halted_next;
	end

	// Register state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_src_q   <= '0;
			dma_len_q   <= '0;
			dma_dst_q   <= '0;
			prog_base_q <= '0;
			page_reg_q  <= '0;
			pc_byte_q   <= '0;
			ctl_a_q     <= 1'b0;
			ctl_b_q     <= '0;
			ctl_c_q     <= '0;
			ctl_d_q     <= 1'b0;
			ctl_e_q     <= 1'b0;
			halted_q    <= 1'b1;
			for (int i = 0; i < 32; i++) begin
				vec_q[i] <= '0;
			end
			for (int i = 0; i < 16; i++) begin
				gpr_q[i] <= '0;
			end
		end else begin
			halted_q <= halted_next;
			if (is_wr) begin
				unique case (dec.sel)
					mmr_pkg::SEL_DMA_SRC: dma_src_q <= put_lane(dma_src_q, dec.lane, d);
					mmr_pkg::SEL_DMA_LEN: begin
						if (dec.lane[0]) begin
							dma_len_q[15:8] <= d;
						end else begin
							dma_len_q[7:0] <= d;
						end
					end
					mmr_pkg::SEL_DMA_DST: dma_dst_q <= put_lane(dma_dst_q, dec.lane, d);
					mmr_pkg::SEL_CTL_A:   ctl_a_q <= d[0];
					mmr_pkg::SEL_PROG:    prog_base_q <= put_lane(prog_base_q, dec.lane, d);
					mmr_pkg::SEL_CTL_B:   ctl_b_q <= d[1:0];
					mmr_pkg::SEL_PAGE: begin
						if (dec.lane[0]) begin
							page_reg_q[14:8] <= d[6:0];
						end else begin
							page_reg_q[7:0] <= d;
						end
					end
					mmr_pkg::SEL_PC:      pc_byte_q <= d;
					mmr_pkg::SEL_CTL_C:   ctl_c_q <= d & mmr_pkg::CTL_C_MASK;
					mmr_pkg::SEL_CTL_D:   ctl_d_q <= d[0];
					mmr_pkg::SEL_CTL_E:   ctl_e_q <= d[0];
					mmr_pkg::SEL_VEC:     vec_q[dec.vec_idx] <= d;
					mmr_pkg::SEL_GPR:
						gpr_q[dec.gpr_idx] <= put_lane(gpr_word, dec.lane, d);
					default: ;
				endcase
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_c;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.run_start |-> rsp_q.running && !halted_q)
		else $error("run_start reported without the core running");

	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(rsp_q.dma_request && rsp_q.run_start))
		else $error("dma_request and run_start in one result");

	a_pc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !rsp_q.run_start |-> rsp_q.start_pc == 23'd0)
		else $error("start_pc set without run_start");

	a_dreq_halted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> !rsp_q.dma_request || $past(halted_q))
		else $error("dma_request raised while running");
`endif

endmodule

### tb/coprocessor_mmio_register_file_tb.sv
// Self-checking testbench for the coprocessor host register window.
`timescale 1ns / 100ps

module coprocessor_mmio_register_file_tb;
	import mmr_pkg::*;

	// Command code with no defined action
	localparam logic [1:0] CMD_NONE = 2'd3;

	// Window map
	localparam logic [9:0] A_DMA_SRC    = 10'h340;
	localparam logic [9:0] A_DMA_LEN    = 10'h343;
	localparam logic [9:0] A_DMA_DST    = 10'h345;
	localparam logic [9:0] A_DMA_DST_HI = 10'h347;
	localparam logic [9:0] A_CTL_A      = 10'h348;
	localparam logic [9:0] A_PROG       = 10'h349;
	localparam logic [9:0] A_CTL_B      = 10'h34C;
	localparam logic [9:0] A_PAGE_LO    = 10'h34D;
	localparam logic [9:0] A_PAGE_HI    = 10'h34E;
	localparam logic [9:0] A_PC         = 10'h34F;
	localparam logic [9:0] A_CTL_C      = 10'h350;
	localparam logic [9:0] A_CTL_D      = 10'h351;
	localparam logic [9:0] A_CTL_E      = 10'h352;
	localparam logic [9:0] A_STATUS_LO  = 10'h353;
	localparam logic [9:0] A_STATUS_HI  = 10'h35F;
	localparam logic [9:0] A_VEC_LO     = 10'h360;
	localparam logic [9:0] A_VEC_HI     = 10'h37F;
	localparam logic [9:0] A_TOP        = 10'h3FF;

	localparam int N_GPR      = 16;
	localparam int N_VEC      = 32;
	localparam int N_DIRECTED = 26;
	localparam int N_RANDOM   = 700;
	localparam int MAX_REPORT = 10;

	typedef struct packed {
		req_t r;
		logic fixed;
		rsp_t want;
	} dir_row_t;

	localparam rsp_t RSP_ZERO = '0;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  rsp;

	// Typed expectation travelling alongside a directed request
	logic  row_fixed;
	rsp_t  row_want;

	// Predicted register contents
	logic [23:0] dma_src, dma_dst, prog_base;
	logic [15:0] dma_len;
	logic [14:0] page_reg;
	logic [7:0]  pc_byte, ctl_c;
	logic        ctl_a, ctl_d, ctl_e;
	logic [1:0]  ctl_b;
	logic [7:0]  vec_tab [N_VEC];
	logic [23:0] gpr [N_GPR];
	logic        core_halted;

	rsp_t resp_q [$];
	int   n_err;

	// Directed requests: extremes, status, masks, halt/run transitions, mirrors
	dir_row_t dir_tab [N_DIRECTED] = '{
		{{CMD_READ,  A_STATUS_LO,  8'h00}, 1'b1, {8'h02, 1'b0, 1'b0, 23'd0, 1'b0}},
		{{CMD_READ,  A_DMA_SRC,    8'h00}, 1'b1, RSP_ZERO},
		{{CMD_WRITE, A_DMA_DST_HI, 8'hFF}, 1'b1, {8'h00, 1'b1, 1'b0, 23'd0, 1'b0}},
		{{CMD_READ,  A_DMA_DST_HI, 8'h00}, 1'b1, {8'hFF, 1'b0, 1'b0, 23'd0, 1'b0}},
		{{CMD_WRITE, A_PAGE_LO,    8'hFF}, 1'b0, RSP_ZERO},
		{{CMD_WRITE, A_PAGE_HI,    8'hFF}, 1'b0, RSP_ZERO},
		{{CMD_READ,  A_PAGE_HI,    8'h00}, 1'b1, {8'h7F, 1'b0, 1'b0, 23'd0, 1'b0}},
		{{CMD_WRITE, A_PC,         8'hFF}, 1'b1, {8'h00, 1'b0, 1'b1, 23'h7FFFFF, 1'b1}},
		{{CMD_READ,  A_STATUS_HI,  8'h00}, 1'b1, {8'h40, 1'b0, 1'b0, 23'd0, 1'b1}},
		{{CMD_WRITE, A_DMA_DST_HI, 8'h00}, 1'b1, {8'h00, 1'b0, 1'b0, 23'd0, 1'b1}},
		{{CMD_WRITE, A_PC,         8'h12}, 1'b1, {8'h00, 1'b0, 1'b0, 23'd0, 1'b1}},
		{{CMD_HALT,  10'h000,      8'h00}, 1'b1, RSP_ZERO},
		{{CMD_HALT,  A_TOP,        8'hFF}, 1'b1, RSP_ZERO},
		{{CMD_WRITE, A_CTL_C,      8'hFF}, 1'b0, RSP_ZERO},
		{{CMD_READ,  A_CTL_C,      8'h00}, 1'b1, {8'h77, 1'b0, 1'b0, 23'd0, 1'b0}},
		{{CMD_WRITE, 10'h355,      8'hAA}, 1'b0, RSP_ZERO},
		{{CMD_READ,  10'h355,      8'h00}, 1'b1, {8'h02, 1'b0, 1'b0, 23'd0, 1'b0}},
		{{CMD_WRITE, 10'h3C0,      8'hA5}, 1'b0, RSP_ZERO},
		{{CMD_READ,  10'h380,      8'h00}, 1'b0, RSP_ZERO},
		{{CMD_WRITE, 10'h3AF,      8'h5A}, 1'b0, RSP_ZERO},
		{{CMD_READ,  10'h3EF,      8'h00}, 1'b0, RSP_ZERO},
		{{CMD_WRITE, 10'h3B0,      8'hFF}, 1'b0, RSP_ZERO},
		{{CMD_READ,  10'h3B0,      8'h00}, 1'b1, RSP_ZERO},
		{{CMD_READ,  A_TOP,        8'h00}, 1'b1, RSP_ZERO},
		{{CMD_NONE,  10'h000,      8'hFF}, 1'b1, RSP_ZERO},
		{{CMD_READ,  10'h000,      8'h00}, 1'b1, RSP_ZERO}
	};

	coprocessor_mmio_register_file u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("coprocessor_mmio_register_file_tb: done, errors");
		$finish;
	end

	// Apply one request to the predicted window and return what the block should answer
	function automatic rsp_t window_access(input req_t r);
		rsp_t       o;
		logic [9:0] a;
		logic [7:0] d;
		int         lane, gi;
		o    = '0;
		a    = r.offset;
		d    = r.wdata;
		lane = a[5:0] % 3;
		gi   = a[5:0] / 3;
		if (r.cmd == CMD_HALT) begin
			core_halted = 1'b1;
		end else if (r.cmd == CMD_READ) begin
			if (a >= A_STATUS_LO && a <= A_STATUS_HI)
				o.rdata = core_halted ? STATUS_HALT : STATUS_RUN;
			else if (a >= A_DMA_SRC && a < A_DMA_LEN)
				o.rdata = dma_src[8*(a-A_DMA_SRC) +: 8];
			else if (a >= A_DMA_LEN && a < A_DMA_DST)
				o.rdata = dma_len[8*(a-A_DMA_LEN) +: 8];
			else if (a >= A_DMA_DST && a <= A_DMA_DST_HI)
				o.rdata = dma_dst[8*(a-A_DMA_DST) +: 8];
			else if (a == A_CTL_A)
				o.rdata = {7'd0, ctl_a};
			else if (a >= A_PROG && a < A_CTL_B)
				o.rdata = prog_base[8*(a-A_PROG) +: 8];
			else if (a == A_CTL_B)
				o.rdata = {6'd0, ctl_b};
			else if (a == A_PAGE_LO)
				o.rdata = page_reg[7:0];
			else if (a == A_PAGE_HI)
				o.rdata = {1'b0, page_reg[14:8]};
			else if (a == A_PC)
				o.rdata = pc_byte;
			else if (a == A_CTL_C)
				o.rdata = ctl_c;
			else if (a == A_CTL_D)
				o.rdata = {7'd0, ctl_d};
			else if (a == A_CTL_E)
				o.rdata = {7'd0, ctl_e};
			else if (a >= A_VEC_LO && a <= A_VEC_HI)
				o.rdata = vec_tab[a[4:0]];
			else if (a[9:7] == 3'b111 && a[5:0] < 6'd48)
				o.rdata = gpr[gi][8*lane +: 8];
		end else if (r.cmd == CMD_WRITE) begin
			// status range and unmapped offsets fall through untouched
			if (a >= A_DMA_SRC && a < A_DMA_LEN)
				dma_src[8*(a-A_DMA_SRC) +: 8] = d;
			else if (a >= A_DMA_LEN && a < A_DMA_DST)
				dma_len[8*(a-A_DMA_LEN) +: 8] = d;
			else if (a >= A_DMA_DST && a <= A_DMA_DST_HI) begin
				dma_dst[8*(a-A_DMA_DST) +: 8] = d;
				if (a == A_DMA_DST_HI && core_halted)
					o.dma_request = 1'b1;
			end else if (a == A_CTL_A)
				ctl_a = d[0];
			else if (a >= A_PROG && a < A_CTL_B)
				prog_base[8*(a-A_PROG) +: 8] = d;
			else if (a == A_CTL_B)
				ctl_b = d[1:0];
			else if (a == A_PAGE_LO)
				page_reg[7:0] = d;
			else if (a == A_PAGE_HI)
				page_reg[14:8] = d[6:0];
			else if (a == A_PC) begin
				pc_byte = d;
				// only a halted core is released
				if (core_halted) begin
					o.run_start = 1'b1;
					o.start_pc  = {page_reg, pc_byte};
					core_halted = 1'b0;
				end
			end else if (a == A_CTL_C)
				ctl_c = d & CTL_C_MASK;
			else if (a == A_CTL_D)
				ctl_d = d[0];
			else if (a == A_CTL_E)
				ctl_e = d[0];
			else if (a >= A_VEC_LO && a <= A_VEC_HI)
				vec_tab[a[4:0]] = d;
			else if (a[9:7] == 3'b111 && a[5:0] < 6'd48)
				gpr[gi][8*lane +: 8] = d;
		end
		o.running = ~core_halted;
		return o;
	endfunction

	// Result check and request capture, both on the sampled values of this edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (resp_q.size() == 0) begin
					n_err++;
					if (n_err <= MAX_REPORT)
						$display("%0t: result with no request pending: %h", $realtime, rsp);
				end else begin
					want = resp_q.pop_front();
					if (rsp.rdata !== want.rdata || rsp.dma_request !== want.dma_request ||
					    rsp.run_start !== want.run_start || rsp.start_pc !== want.start_pc ||
					    rsp.running !== want.running) begin
						n_err++;
						if (n_err <= MAX_REPORT) begin
							$display("%0t: mismatch (exp/got) rdata %h/%h dreq %b/%b",
								$realtime, want.rdata, rsp.rdata, want.dma_request,
								rsp.dma_request);
							$display("  run %b/%b pc %h/%h rng %b/%b",
								want.run_start, rsp.run_start, want.start_pc,
								rsp.start_pc, want.running, rsp.running);
						end
					end
				end
			end
			if (start && !busy) begin
				want = window_access(req);
				resp_q.push_back(row_fixed ? row_want : want);
			end
		end
	end

	// Present one request and hold it until accepted, then idle at random
	task automatic issue(input req_t r, input logic fixed, input rsp_t want, input int idle_pct);
		int gap;
		start     <= 1'b1;
		req       <= r;
		row_fixed <= fixed;
		row_want  <= want;
		do @(posedge clk); while (busy);
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			if (gap == 0)
				start <= 1'b0;
			gap++;
			@(posedge clk);
		end
	endtask

	// Wait for every outstanding result
	task automatic drain();
		int k;
		for (k = 0; k < 1000 && resp_q.size() != 0; k++)
			@(posedge clk);
	endtask

	initial begin
		req_t r;
		int   ph, i, pick, idle_pct;
		n_err       = 0;
		dma_src     = '0;
		dma_dst     = '0;
		prog_base   = '0;
		dma_len     = '0;
		page_reg    = '0;
		pc_byte     = '0;
		ctl_a       = 1'b0;
		ctl_b       = '0;
		ctl_c       = '0;
		ctl_d       = 1'b0;
		ctl_e       = 1'b0;
		core_halted = 1'b1;
		for (i = 0; i < N_VEC; i++) vec_tab[i] = '0;
		for (i = 0; i < N_GPR; i++) gpr[i] = '0;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		row_fixed = 1'b0;
		row_want  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests
		for (i = 0; i < N_DIRECTED; i++)
			issue(dir_tab[i].r, dir_tab[i].fixed, dir_tab[i].want, 8);

		// Random requests in three idling phases, sender holding off between them
		for (ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 8 : (ph == 1) ? 75 : 0;
			start <= 1'b0;
			do @(posedge clk); while (resp_q.size() != 0);
			for (i = 0; i < N_RANDOM / 3; i++) begin
				pick = $urandom_range(0, 99);
				r.cmd = (pick < 45) ? CMD_READ : (pick < 88) ? CMD_WRITE :
				        (pick < 97) ? CMD_HALT : CMD_NONE;
				// mostly the mapped top of the window, with run and DMA triggers favoured
				case ($urandom_range(0, 9))
					0, 1: r.offset = 10'($urandom_range(0, 1023));
					2: r.offset = $urandom_range(0, 1) ? A_PC : A_DMA_DST_HI;
					default: r.offset = 10'($urandom_range(A_DMA_SRC, A_TOP));
				endcase
				r.wdata = 8'($urandom_range(0, 255));
				issue(r, 1'b0, RSP_ZERO, idle_pct);
			end
		end

		start <= 1'b0;
		drain();
		repeat (4) @(posedge clk);
		n_err += resp_q.size();
		if (n_err == 0)
			$display("coprocessor_mmio_register_file_tb: done, clean");
		else
			$display("coprocessor_mmio_register_file_tb: done, errors");
		$finish;
	end

endmodule
